>>> rtl/core/fpca_pkg.sv
// shared types, constants and helpers for the pixel color access block
package fpca_pkg;

   localparam int ADDR_BITS  = 16;
   localparam int ROW_STRIDE = 40;
   localparam int COLOUR_OFS = 'h400;
   // luma and colour bytes always differ in this address bit, so it picks the bank
   localparam int BANK_SEL   = $clog2(COLOUR_OFS);
   localparam int BANK_BITS  = ADDR_BITS - 1;
   localparam int BANK_DEPTH = 1 << BANK_BITS;

   localparam int XPOS_W  = 7;
   localparam int YPOS_W  = 8;
   localparam int BYTE_W  = 8;
   localparam int BASE_W  = 16;
   localparam int CSR_IDX_W = 3;
   localparam int NUM_BASE  = 8;

   localparam int UPPER_END = 96;
   localparam int LOWER_END = 100;
   localparam int SPLIT_END = 104;
   localparam int SPLIT_X   = 48;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_RAW   = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef struct packed {
      logic load;     // capture an accepted item and its addresses
      logic mem_rd;   // read both bytes
      logic commit;   // write back and load the result register
   } fpca_cmd_type;

   // byte address inside a bank: the bank select bit is dropped
   function automatic logic [BANK_BITS-1:0] bank_addr(input logic [ADDR_BITS-1:0] a);
      bank_addr = {a[ADDR_BITS-1:BANK_SEL+1], a[BANK_SEL-1:0]};
   endfunction

endpackage

>>> rtl/core/fli_pixel_color_access_top.sv
// top level of the pixel color access block
//
//  port group | direction | carries
//  req_*      | in        | one access: op in tuser, coordinates and bytes in tdata
//  rsp_*      | out       | colour read and luma address for each access
//  csr_*      | in        | writes to the eight base registers
//
// an access passes through accept, memory read, then write back and result load;
// the video memory is two banks split on address bit 10, so the luma and colour
// bytes are read in the same cycle and written in the same cycle
// a new access is taken once the previous one has loaded its result register
// a stalled result holds the block in its write-back cycle until taken
// reset clears the base registers and control; video memory is not cleared
module fli_pixel_color_access_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [1:0]                           req_tuser,  // op
   // xpos, ypos, pixel_color, raw_colour_byte, raw_luma_byte, zero pad
   input  logic [fpca_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [fpca_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // color_out, luma_address
   input  logic                                 csr_we,
   input  logic [fpca_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fpca_pkg::BASE_W-1:0]          csr_wdata
);

   fpca_pkg::fpca_cmd_type cmd;

   fpca_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   fpca_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> rtl/core/fpca_ctrl.sv
// controller state machine for the pixel color access block
module fpca_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output fpca_pkg::fpca_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RD   = 3'b010,
      ST_WR   = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_WR;
         end
         ST_WR: begin
            // hold here while the previous result still waits
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/core/fpca_datapath.sv
// base registers, address calculation, banked video memory and result register
module fpca_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fpca_pkg::fpca_cmd_type               cmd,
   input  logic [1:0]                           req_tuser,
   input  logic [fpca_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 csr_we,
   input  logic [fpca_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fpca_pkg::BASE_W-1:0]          csr_wdata,
   output logic [fpca_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int AW = fpca_pkg::ADDR_BITS;
   localparam int BW = fpca_pkg::BANK_BITS;
   localparam int XW = fpca_pkg::XPOS_W;
   localparam int YW = fpca_pkg::YPOS_W;
   localparam int DW = fpca_pkg::BYTE_W;

   logic [fpca_pkg::BASE_W-1:0] base_ff [fpca_pkg::NUM_BASE];

   logic [XW-1:0] xpos;
   logic [YW-1:0] ypos;
   logic [DW-1:0] pixel_color, raw_colour_byte, raw_luma_byte;
   logic [AW-1:0] row_ofs, base_sel, la_calc;
   logic [1:0]    sel;

   fpca_pkg::op_type op_ff;
   logic             bg_ff;
   logic [DW-1:0]    color_ff, raw_c_ff, raw_l_ff;
   logic [AW-1:0]    la_ff, ca_ff;

   logic [DW-1:0] bank0_mem [fpca_pkg::BANK_DEPTH];
   logic [DW-1:0] bank1_mem [fpca_pkg::BANK_DEPTH];
   logic [DW-1:0] bank0_rd_ff, bank1_rd_ff;
   logic [BW-1:0] bank0_addr, bank1_addr;
   logic [DW-1:0] bank0_wdata, bank1_wdata;
   logic          mem_we;

   logic [DW-1:0] luma_rd, colour_rd, luma_new, colour_new, color_out;
   logic [DW-1:0] color_out_ff;

   assign xpos            = req_tdata[XW-1:0];
   assign ypos            = req_tdata[XW+YW-1:XW];
   assign pixel_color     = req_tdata[XW+YW+DW-1:XW+YW];
   assign raw_colour_byte = req_tdata[XW+YW+2*DW-1:XW+YW+DW];
   assign raw_luma_byte   = req_tdata[XW+YW+3*DW-1:XW+YW+2*DW];

   // base register by ypos mod 4 and screen region
   always_comb begin
      sel     = ypos[1:0];
      row_ofs = AW'(ypos[YW-1:2] * fpca_pkg::ROW_STRIDE) + AW'(xpos[XW-1:1]);
      if (ypos < YW'(fpca_pkg::UPPER_END)) begin
         base_sel = AW'(base_ff[{1'b0, sel}]);
      end else if (ypos < YW'(fpca_pkg::LOWER_END) ||
                   (ypos < YW'(fpca_pkg::SPLIT_END) && xpos < XW'(fpca_pkg::SPLIT_X))) begin
         base_sel = AW'(base_ff[{1'b1, sel}]);
      end else begin
         base_sel = AW'(base_ff[{1'b1, sel}]) - AW'(fpca_pkg::COLOUR_OFS);
      end
      la_calc = base_sel + row_ofs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fpca_pkg::NUM_BASE; i++) begin
            base_ff[i] <= '0;
         end
      end else if (csr_we) begin
         base_ff[csr_index] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= fpca_pkg::op_type'(req_tuser);
         bg_ff    <= xpos[0];
         color_ff <= pixel_color;
         raw_c_ff <= raw_colour_byte;
         raw_l_ff <= raw_luma_byte;
         la_ff    <= la_calc;
         ca_ff    <= la_calc + AW'(fpca_pkg::COLOUR_OFS);
      end
   end

   // luma sits in bank la[sel bit], colour in the other bank
   assign bank0_addr = la_ff[fpca_pkg::BANK_SEL] ? fpca_pkg::bank_addr(ca_ff)
                                                 : fpca_pkg::bank_addr(la_ff);
   assign bank1_addr = la_ff[fpca_pkg::BANK_SEL] ? fpca_pkg::bank_addr(la_ff)
                                                 : fpca_pkg::bank_addr(ca_ff);

   assign luma_rd   = la_ff[fpca_pkg::BANK_SEL] ? bank1_rd_ff : bank0_rd_ff;
   assign colour_rd = la_ff[fpca_pkg::BANK_SEL] ? bank0_rd_ff : bank1_rd_ff;

   always_comb begin
      color_out  = '0;
      luma_new   = luma_rd;
      colour_new = colour_rd;
      mem_we     = 1'b0;
      case (op_ff)
         fpca_pkg::OP_READ: begin
            if (bg_ff) begin
               color_out = {luma_rd[3:0], colour_rd[7:4]};
            end else begin
               color_out = {luma_rd[7:4], colour_rd[3:0]};
            end
         end
         fpca_pkg::OP_WRITE: begin
            mem_we = 1'b1;
            if (bg_ff) begin
               colour_new = {color_ff[3:0], colour_rd[3:0]};
               luma_new   = {luma_rd[7:4], color_ff[7:4]};
            end else begin
               colour_new = {colour_rd[7:4], color_ff[3:0]};
               luma_new   = {color_ff[7:4], luma_rd[3:0]};
            end
         end
         fpca_pkg::OP_RAW: begin
            mem_we     = 1'b1;
            colour_new = raw_c_ff;
            luma_new   = raw_l_ff;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   assign bank0_wdata = la_ff[fpca_pkg::BANK_SEL] ? colour_new : luma_new;
   assign bank1_wdata = la_ff[fpca_pkg::BANK_SEL] ? luma_new : colour_new;

   always_ff @(posedge clock) begin
      if (cmd.commit && mem_we) begin
         bank0_mem[bank0_addr] <= bank0_wdata;
      end
      if (cmd.mem_rd) begin
         bank0_rd_ff <= bank0_mem[bank0_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && mem_we) begin
         bank1_mem[bank1_addr] <= bank1_wdata;
      end
      if (cmd.mem_rd) begin
         bank1_rd_ff <= bank1_mem[bank1_addr];
      end
   end

   logic [AW-1:0] addr_out_ff;

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         color_out_ff <= color_out;
         addr_out_ff  <= la_ff;
      end
   end

   assign rsp_tdata = {addr_out_ff, color_out_ff};

endmodule

>>> rtl/core/fpca_checker.sv
// port-level checks for the pixel color access block, bound to the top level
module fpca_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [fpca_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // after reset the block is empty and ready
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (req_tready && !rsp_tvalid))
      else $error("block not empty after reset");

   // an access keeps the input closed for its read and write-back cycles
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready ##1 !req_tready)
      else $error("input reopened during an access");

   // a stalled result stays and holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   // the input cannot reopen while a result is stuck behind a stall
   a_no_accept_over_stall: assert property (@(posedge clock) disable iff (reset)
      (!req_tready && rsp_tvalid && !rsp_tready) |=> !(req_tvalid && req_tready && !rsp_tvalid))
      else $error("result lost behind a stall");

endmodule

bind fli_pixel_color_access_top fpca_checker u_fpca_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
